/* rtl/core/assert_macros.svh */
// Assertion macros shared by the preflagger RTL; empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define VP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define VP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define VP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/vp_pkg.sv */
// Shared types, codes and defaults of the visibility preflagger.
package vp_pkg;

    // Default sizes
    localparam int NUM_ANTENNAS_DEF     = 64;
    localparam int NUM_CHANNELS_DEF     = 256;
    localparam int NUM_CORRELATIONS_DEF = 4;

    // Mask word and config port widths
    localparam int MASK_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Item commands
    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_WR_ROW  = 2'd1;
    localparam logic [1:0] CMD_WR_CHAN = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UV_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UV_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPL_LOW_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPL_LOW_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMPL_HIGH_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMPL_HIGH_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLES     = 3'd6;

    // Enable bit positions
    localparam int EN_UV       = 0;
    localparam int EN_BASELINE = 1;
    localparam int EN_AMPL     = 2;
    localparam int EN_CHAN     = 3;

    // Reset value of the upper uv bound (2^47)
    localparam logic [47:0] UV_MAX_RST = 48'h8000_0000_0000;

    // Config register contents
    typedef struct packed {
        logic [47:0] uv_min_sq;
        logic [47:0] uv_max_sq;
        logic [63:0] ampl_low_a;
        logic [63:0] ampl_low_b;
        logic [63:0] ampl_high_a;
        logic [63:0] ampl_high_b;
        logic [3:0]  enables;
    } cfg_t;

    // Stage load strobes from the pipeline control
    typedef struct packed {
        logic accept;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctrl_t;

endpackage

/* rtl/core/vp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/vp_cfg_regs.sv */
// Configuration register file of the preflagger.
module vp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [vp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vp_pkg::CFG_DATA_W-1:0] cfg_data,
    output vp_pkg::cfg_t                  cfg
);

    vp_pkg::cfg_t cfg_reg;
    vp_pkg::cfg_t cfg_next;

    // Decode a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                vp_pkg::REG_UV_MIN:      cfg_next.uv_min_sq   = cfg_data[47:0];
                vp_pkg::REG_UV_MAX:      cfg_next.uv_max_sq   = cfg_data[47:0];
                vp_pkg::REG_AMPL_LOW_A:  cfg_next.ampl_low_a  = cfg_data;
                vp_pkg::REG_AMPL_LOW_B:  cfg_next.ampl_low_b  = cfg_data;
                vp_pkg::REG_AMPL_HIGH_A: cfg_next.ampl_high_a = cfg_data;
                vp_pkg::REG_AMPL_HIGH_B: cfg_next.ampl_high_b = cfg_data;
                vp_pkg::REG_ENABLES:     cfg_next.enables     = cfg_data[3:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uv_min_sq   <= '0;
            cfg_reg.uv_max_sq   <= vp_pkg::UV_MAX_RST;
            cfg_reg.ampl_low_a  <= '0;
            cfg_reg.ampl_low_b  <= '0;
            cfg_reg.ampl_high_a <= '1;
            cfg_reg.ampl_high_b <= '1;
            cfg_reg.enables     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/vp_mask_tables.sv */
// Baseline and channel mask tables: RAMs with per-entry valid bits.
module vp_mask_tables #(
    parameter int NUM_ANTENNAS = vp_pkg::NUM_ANTENNAS_DEF,
    parameter int NUM_CHANNELS = vp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [1:0]                command,
    input  logic [5:0]                table_addr,
    input  logic [vp_pkg::MASK_W-1:0] table_data,
    input  logic [5:0]                first_antenna,
    input  logic [7:0]                channel,
    output logic [vp_pkg::MASK_W-1:0] row_bits,
    output logic [vp_pkg::MASK_W-1:0] chan_bits
);

    localparam int ROW_AW     = $clog2(NUM_ANTENNAS);
    localparam int CHAN_WORDS = (NUM_CHANNELS + 63) / 64;
    localparam int WORD_AW    = (CHAN_WORDS > 1) ? $clog2(CHAN_WORDS) : 1;

    logic                      row_we;
    logic                      word_we;
    logic                      rd_en;
    logic [5:0]                chan_word;
    logic [ROW_AW-1:0]         row_waddr;
    logic [ROW_AW-1:0]         row_raddr;
    logic [WORD_AW-1:0]        word_waddr;
    logic [WORD_AW-1:0]        word_raddr;
    logic [vp_pkg::MASK_W-1:0] row_rdata;
    logic [vp_pkg::MASK_W-1:0] word_rdata;

    logic [NUM_ANTENNAS-1:0]   row_vld_reg;
    logic [NUM_ANTENNAS-1:0]   row_vld_next;
    logic [CHAN_WORDS-1:0]     word_vld_reg;
    logic [CHAN_WORDS-1:0]     word_vld_next;
    logic                      row_ok_reg;
    logic                      word_ok_reg;

    // Writes and reads happen as the word is taken in
    assign row_we  = accept && (command == vp_pkg::CMD_WR_ROW)
                     && ({26'd0, table_addr} < 32'(NUM_ANTENNAS));
    assign word_we = accept && (command == vp_pkg::CMD_WR_CHAN)
                     && ({26'd0, table_addr} < 32'(CHAN_WORDS));
    assign rd_en   = accept && (command == vp_pkg::CMD_SAMPLE);

    assign chan_word  = {4'd0, channel[7:6]};
    assign row_waddr  = table_addr[ROW_AW-1:0];
    assign row_raddr  = first_antenna[ROW_AW-1:0];
    assign word_waddr = table_addr[WORD_AW-1:0];
    assign word_raddr = chan_word[WORD_AW-1:0];

    vp_ram #(
        .WIDTH (vp_pkg::MASK_W),
        .DEPTH (NUM_ANTENNAS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (table_data),
        .re    (rd_en),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    vp_ram #(
        .WIDTH (vp_pkg::MASK_W),
        .DEPTH (CHAN_WORDS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (table_data),
        .re    (rd_en),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    // Valid bits: an unwritten entry reads as zero
    always_comb
    begin
        row_vld_next  = row_vld_reg;
        word_vld_next = word_vld_reg;
        if (row_we)
        begin
            row_vld_next[row_waddr] = 1'b1;
        end
        if (word_we)
        begin
            word_vld_next[word_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg  <= '0;
            word_vld_reg <= '0;
            row_ok_reg   <= 1'b0;
            word_ok_reg  <= 1'b0;
        end
        else
        begin
            row_vld_reg  <= row_vld_next;
            word_vld_reg <= word_vld_next;
            if (rd_en)
            begin
                row_ok_reg  <= row_vld_reg[row_raddr];
                word_ok_reg <= word_vld_reg[word_raddr];
            end
        end
    end

    assign row_bits  = row_ok_reg  ? row_rdata  : '0;
    assign chan_bits = word_ok_reg ? word_rdata : '0;

endmodule

/* rtl/core/vp_test_pipe.sv */
// Four-stage datapath: capture, square, sum, compare and flag.
module vp_test_pipe #(
    parameter int NUM_ANTENNAS     = vp_pkg::NUM_ANTENNAS_DEF,
    parameter int NUM_CHANNELS     = vp_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_CORRELATIONS = vp_pkg::NUM_CORRELATIONS_DEF
) (
    input  logic                      clk,
    input  vp_pkg::pipe_ctrl_t        ctrl,
    input  vp_pkg::cfg_t              cfg,
    input  logic [1:0]                command,
    input  logic [5:0]                first_antenna,
    input  logic [5:0]                second_antenna,
    input  logic [7:0]                channel,
    input  logic [1:0]                correlation,
    input  logic signed [23:0]        coord_u,
    input  logic signed [23:0]        coord_v,
    input  logic signed [15:0]        real_part,
    input  logic signed [15:0]        imag_part,
    input  logic                      flag_in,
    input  logic [vp_pkg::MASK_W-1:0] row_bits,
    input  logic [vp_pkg::MASK_W-1:0] chan_bits,
    output logic                      flag_out,
    output logic                      uv_hit,
    output logic                      baseline_hit,
    output logic                      ampl_hit,
    output logic                      chan_hit
);

    // Stage 1: captured input word
    logic               s1_sample_reg;
    logic               s1_flag_reg;
    logic [5:0]         s1_a1_reg;
    logic [5:0]         s1_a2_reg;
    logic [7:0]         s1_ch_reg;
    logic [1:0]         s1_corr_reg;
    logic signed [23:0] s1_u_reg;
    logic signed [23:0] s1_v_reg;
    logic signed [15:0] s1_re_reg;
    logic signed [15:0] s1_im_reg;

    // Stage 2: squares and table hits
    logic               s2_sample_reg;
    logic               s2_flag_reg;
    logic               s2_bl_reg;
    logic               s2_ch_reg;
    logic               s2_ampl_en_reg;
    logic [46:0]        s2_uu_reg;
    logic [46:0]        s2_vv_reg;
    logic [30:0]        s2_rr_reg;
    logic [30:0]        s2_ii_reg;
    logic [31:0]        s2_lo_reg;
    logic [31:0]        s2_hi_reg;

    // Stage 3: sums
    logic               s3_sample_reg;
    logic               s3_flag_reg;
    logic               s3_bl_reg;
    logic               s3_ch_reg;
    logic               s3_ampl_en_reg;
    logic [47:0]        s3_dist_reg;
    logic [31:0]        s3_pwr_reg;
    logic [31:0]        s3_lo_reg;
    logic [31:0]        s3_hi_reg;

    // Stage 4: output word
    logic               s4_flag_reg;
    logic               s4_uv_reg;
    logic               s4_bl_reg;
    logic               s4_ampl_reg;
    logic               s4_ch_reg;

    logic signed [47:0] uu_full;
    logic signed [47:0] vv_full;
    logic signed [31:0] rr_full;
    logic signed [31:0] ii_full;
    logic               bl_now;
    logic               ch_now;
    logic               ampl_en_now;
    logic [63:0]        lo_pair;
    logic [63:0]        hi_pair;
    logic [31:0]        lo_now;
    logic [31:0]        hi_now;
    logic               uv_now;
    logic               ampl_now;

    // Stage 1 capture
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            s1_sample_reg <= (command == vp_pkg::CMD_SAMPLE);
            s1_flag_reg   <= flag_in;
            s1_a1_reg     <= first_antenna;
            s1_a2_reg     <= second_antenna;
            s1_ch_reg     <= channel;
            s1_corr_reg   <= correlation;
            s1_u_reg      <= coord_u;
            s1_v_reg      <= coord_v;
            s1_re_reg     <= real_part;
            s1_im_reg     <= imag_part;
        end
    end

    // Squares, table bit selects and bound selection
    assign uu_full = s1_u_reg * s1_u_reg;
    assign vv_full = s1_v_reg * s1_v_reg;
    assign rr_full = s1_re_reg * s1_re_reg;
    assign ii_full = s1_im_reg * s1_im_reg;

    assign bl_now = s1_sample_reg && cfg.enables[vp_pkg::EN_BASELINE]
                    && ({26'd0, s1_a1_reg} < 32'(NUM_ANTENNAS))
                    && ({26'd0, s1_a2_reg} < 32'(NUM_ANTENNAS))
                    && row_bits[s1_a2_reg];
    assign ch_now = s1_sample_reg && cfg.enables[vp_pkg::EN_CHAN]
                    && ({24'd0, s1_ch_reg} < 32'(NUM_CHANNELS))
                    && chan_bits[s1_ch_reg[5:0]];
    assign ampl_en_now = s1_sample_reg && cfg.enables[vp_pkg::EN_AMPL]
                         && ({30'd0, s1_corr_reg} < 32'(NUM_CORRELATIONS));

    assign lo_pair = s1_corr_reg[1] ? cfg.ampl_low_b  : cfg.ampl_low_a;
    assign hi_pair = s1_corr_reg[1] ? cfg.ampl_high_b : cfg.ampl_high_a;
    assign lo_now  = s1_corr_reg[0] ? lo_pair[63:32]  : lo_pair[31:0];
    assign hi_now  = s1_corr_reg[0] ? hi_pair[63:32]  : hi_pair[31:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.ld2)
        begin
            s2_sample_reg  <= s1_sample_reg;
            s2_flag_reg    <= s1_flag_reg;
            s2_bl_reg      <= bl_now;
            s2_ch_reg      <= ch_now;
            s2_ampl_en_reg <= ampl_en_now;
            s2_uu_reg      <= uu_full[46:0];
            s2_vv_reg      <= vv_full[46:0];
            s2_rr_reg      <= rr_full[30:0];
            s2_ii_reg      <= ii_full[30:0];
            s2_lo_reg      <= lo_now;
            s2_hi_reg      <= hi_now;
        end
    end

    // Sums of squares
    always_ff @(posedge clk)
    begin
        if (ctrl.ld3)
        begin
            s3_sample_reg  <= s2_sample_reg;
            s3_flag_reg    <= s2_flag_reg;
            s3_bl_reg      <= s2_bl_reg;
            s3_ch_reg      <= s2_ch_reg;
            s3_ampl_en_reg <= s2_ampl_en_reg;
            s3_dist_reg    <= {1'b0, s2_uu_reg} + {1'b0, s2_vv_reg};
            s3_pwr_reg     <= {1'b0, s2_rr_reg} + {1'b0, s2_ii_reg};
            s3_lo_reg      <= s2_lo_reg;
            s3_hi_reg      <= s2_hi_reg;
        end
    end

    // Bound compares and flag merge
    assign uv_now   = s3_sample_reg && cfg.enables[vp_pkg::EN_UV]
                      && ((s3_dist_reg < cfg.uv_min_sq) || (s3_dist_reg > cfg.uv_max_sq));
    assign ampl_now = s3_ampl_en_reg
                      && ((s3_pwr_reg < s3_lo_reg) || (s3_pwr_reg > s3_hi_reg));

    always_ff @(posedge clk)
    begin
        if (ctrl.ld4)
        begin
            s4_uv_reg   <= uv_now;
            s4_bl_reg   <= s3_bl_reg;
            s4_ampl_reg <= ampl_now;
            s4_ch_reg   <= s3_ch_reg;
            s4_flag_reg <= s3_sample_reg
                           && (s3_flag_reg || uv_now || s3_bl_reg || ampl_now || s3_ch_reg);
        end
    end

    assign flag_out     = s4_flag_reg;
    assign uv_hit       = s4_uv_reg;
    assign baseline_hit = s4_bl_reg;
    assign ampl_hit     = s4_ampl_reg;
    assign chan_hit     = s4_ch_reg;

endmodule

/* rtl/core/visibility_preflagger_core.sv */
// Top level of the visibility preflagger: pipeline control and wiring.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    command .. table_data
//  out       source     out_valid / out_stall  flag_out, uv_hit .. chan_hit
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
// One word per cycle while out_stall lets the pipe move; out_valid rises when the word reaches the last stage.
// Stages: capture and table read, squaring multipliers, sums, bound compares.
// Reset clears config to defaults and invalidates every mask table entry at once.
// A stall holds the output word; empty stages behind it keep filling.
// Table write words leave through the pipe as all-zero results, in order.
`include "assert_macros.svh"

module visibility_preflagger_core #(
    parameter int NUM_ANTENNAS     = vp_pkg::NUM_ANTENNAS_DEF,
    parameter int NUM_CHANNELS     = vp_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_CORRELATIONS = vp_pkg::NUM_CORRELATIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [5:0]                    first_antenna,
    input  logic [5:0]                    second_antenna,
    input  logic [7:0]                    channel,
    input  logic [1:0]                    correlation,
    input  logic signed [23:0]            coord_u,
    input  logic signed [23:0]            coord_v,
    input  logic signed [15:0]            real_part,
    input  logic signed [15:0]            imag_part,
    input  logic                          flag_in,
    input  logic [5:0]                    table_addr,
    input  logic [vp_pkg::MASK_W-1:0]     table_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          flag_out,
    output logic                          uv_hit,
    output logic                          baseline_hit,
    output logic                          ampl_hit,
    output logic                          chan_hit,
    input  logic                          cfg_write,
    input  logic [vp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vp_pkg::CFG_DATA_W-1:0] cfg_data
);

    vp_pkg::cfg_t       cfg;
    vp_pkg::pipe_ctrl_t ctrl;
    logic [vp_pkg::MASK_W-1:0] row_bits;
    logic [vp_pkg::MASK_W-1:0] chan_bits;

    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    logic v4_next;

    // A stage loads when empty or when the one ahead moves on
    assign ld4 = !v4_reg || !out_stall;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign v1_next = ld1 ? in_valid : v1_reg;
    assign v2_next = ld2 ? v1_reg   : v2_reg;
    assign v3_next = ld3 ? v2_reg   : v3_reg;
    assign v4_next = ld4 ? v3_reg   : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_stall    = !ld1;
    assign out_valid   = v4_reg;
    assign ctrl.accept = in_valid && ld1;
    assign ctrl.ld2    = ld2;
    assign ctrl.ld3    = ld3;
    assign ctrl.ld4    = ld4;

    vp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vp_mask_tables #(
        .NUM_ANTENNAS (NUM_ANTENNAS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_mask_tables (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (ctrl.accept),
        .command       (command),
        .table_addr    (table_addr),
        .table_data    (table_data),
        .first_antenna (first_antenna),
        .channel       (channel),
        .row_bits      (row_bits),
        .chan_bits     (chan_bits)
    );

    vp_test_pipe #(
        .NUM_ANTENNAS     (NUM_ANTENNAS),
        .NUM_CHANNELS     (NUM_CHANNELS),
        .NUM_CORRELATIONS (NUM_CORRELATIONS)
    ) u_test_pipe (
        .clk            (clk),
        .ctrl           (ctrl),
        .cfg            (cfg),
        .command        (command),
        .first_antenna  (first_antenna),
        .second_antenna (second_antenna),
        .channel        (channel),
        .correlation    (correlation),
        .coord_u        (coord_u),
        .coord_v        (coord_v),
        .real_part      (real_part),
        .imag_part      (imag_part),
        .flag_in        (flag_in),
        .row_bits       (row_bits),
        .chan_bits      (chan_bits),
        .flag_out       (flag_out),
        .uv_hit         (uv_hit),
        .baseline_hit   (baseline_hit),
        .ampl_hit       (ampl_hit),
        .chan_hit       (chan_hit)
    );

    // Any empty stage means the input side is open
    `VP_ASSERT_ALWAYS(a_bubble_opens_input, clk, (!v1_reg || !v2_reg || !v3_reg || !v4_reg) |-> !in_stall, "input stalled with a free stage")
    // An accepted word lands in stage one
    `VP_ASSERT_CLK(a_accept_fills_s1, clk, rst_n, (in_valid && !in_stall) |=> v1_reg, "accepted word lost")
    // Any hit on the output forces the flag
    `VP_ASSERT_CLK(a_hit_sets_flag, clk, rst_n, (out_valid && (uv_hit || baseline_hit || ampl_hit || chan_hit)) |-> flag_out, "hit without flag")

endmodule
